/* hdl/cnms_pkg.sv */
// shared types, constants and calendar helpers for the cron next-match search
`timescale 1ns / 1ps
package cnms_pkg;

	localparam int MAX_DAY_STEPS   = 1000;
	localparam int MAX_YEARS_AHEAD = 10;
	localparam int YEAR_CYCLE      = 400;
	localparam int CENTURY         = 100;
	localparam int FEB_BASE_DAYS   = 28;
	localparam int SHORT_MONTH     = 30;
	localparam int FEBRUARY        = 1;
	localparam int LAST_MONTH      = 11;
	localparam int LAST_WEEKDAY    = 6;
	localparam int LAST_HOUR       = 23;
	localparam int LAST_MINUTE     = 59;
	localparam int HOURS_PER_DAY   = 24;
	localparam int MINUTES_PER_HR  = 60;
	localparam int DAYS_PER_WEEK   = 7;
	localparam logic [15:0] LONG_MONTHS = 16'h15AA;

	localparam int STEP_W = 10;
	localparam int WYEAR_W = 13;
	localparam int YMOD_W = 9;

	// search cursor: calendar day plus year phase within the 400-year cycle
	typedef struct packed {
		logic [WYEAR_W-1:0] year;
		logic [YMOD_W-1:0]  ymod;
		logic [3:0]         month;
		logic [5:0]         day;
		logic [2:0]         weekday;
	} cal_pos_t;

	typedef struct packed {
		logic [59:0] minute_mask;
		logic [23:0] hour_mask;
		logic [30:0] day_of_month_mask;
		logic [11:0] month_mask;
		logic [6:0]  weekday_mask;
	} cfg_t;

	typedef enum logic [2:0] {
		CFG_MINUTE_MASK  = 3'd0,
		CFG_HOUR_MASK    = 3'd1,
		CFG_DOM_MASK     = 3'd2,
		CFG_MONTH_MASK   = 3'd3,
		CFG_WEEKDAY_MASK = 3'd4
	} cfg_idx_t;

	function automatic logic leap_f(input logic [YMOD_W-1:0] ymod, input logic [1:0] ylo);
		logic res;
		if (ymod == YMOD_W'(0)) begin
			res = 1'b1;
		end else if (ymod == YMOD_W'(CENTURY) || ymod == YMOD_W'(2*CENTURY) ||
			ymod == YMOD_W'(3*CENTURY)) begin
			res = 1'b0;
		end else begin
			res = (ylo == 2'd0);
		end
		return res;
	endfunction

	// remainder by seven for values below 56
	function automatic logic [2:0] mod7_f(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (r >= 6'(4*DAYS_PER_WEEK)) r = r - 6'(4*DAYS_PER_WEEK);
		if (r >= 6'(2*DAYS_PER_WEEK)) r = r - 6'(2*DAYS_PER_WEEK);
		if (r >= 6'(DAYS_PER_WEEK)) r = r - 6'(DAYS_PER_WEEK);
		return r[2:0];
	endfunction

endpackage

/* hdl/cnms_cfg_regs.sv */
// configuration mask registers of the cron next-match search
`timescale 1ns / 1ps
module cnms_cfg_regs
	import cnms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MINUTE_MASK:  cfg_q.minute_mask       <= cfg_wdata;
				CFG_HOUR_MASK:    cfg_q.hour_mask         <= cfg_wdata[23:0];
				CFG_DOM_MASK:     cfg_q.day_of_month_mask <= cfg_wdata[30:0];
				CFG_MONTH_MASK:   cfg_q.month_mask        <= cfg_wdata[11:0];
				CFG_WEEKDAY_MASK: cfg_q.weekday_mask      <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/cnms_cal_unit.sv */
// shared calendar unit: month length and month rollover of the search cursor
`timescale 1ns / 1ps
module cnms_cal_unit
	import cnms_pkg::*;
(
	input  cal_pos_t   pos,
	output logic [4:0] month_len,
	output cal_pos_t   pos_next_month
);

	logic [3:0] mi;

	always_comb begin
		mi = pos.month + 4'd1;
		if (pos.month == 4'(FEBRUARY)) begin
			month_len = 5'(FEB_BASE_DAYS) + 5'(leap_f(pos.ymod, pos.year[1:0]));
		end else begin
			month_len = 5'(SHORT_MONTH) + 5'(LONG_MONTHS[mi]);
		end
	end

	// first day of the following month, year and cycle phase carried
	always_comb begin
		pos_next_month = pos;
		pos_next_month.day = 6'd1;
		if (pos.month >= 4'(LAST_MONTH)) begin
			pos_next_month.month = 4'd0;
			pos_next_month.year = pos.year + WYEAR_W'(1);
			if (pos.ymod == YMOD_W'(YEAR_CYCLE - 1)) begin
				pos_next_month.ymod = '0;
			end else begin
				pos_next_month.ymod = pos.ymod + YMOD_W'(1);
			end
		end else begin
			pos_next_month.month = pos.month + 4'd1;
		end
	end

endmodule

/* hdl/cron_next_match_search.sv */
// top level: sequencer of the cron next-match search
`timescale 1ns / 1ps
// cron next-match search
// input channel (in_valid/in_ready) carries a calendar minute: year, month,
// day_of_month, weekday, hour, minute. output channel (out_valid/out_ready)
// returns one item per input: found plus the next minute that the five masks
// allow, or found low with all other fields zero when the search fails.
// the user must write masks through cfg_we/cfg_index/cfg_wdata only while the
// block is idle; the block itself does not enforce this. an index above four is ignored.
// one search at a time: in_ready is high only while the sequencer is idle.
// each item goes through accept, year-phase reduction (up to ten subtracts of
// 400, then the phase is latched), a check, the minute scan, the hour scan, a
// fixup, then day steps (at most 1000) with one final day check and skipped
// months, and the hand-over of the result to the output register; all calendar
// steps share one month-length and rollover unit, one step per cycle.
// the result waits in an output register until out_ready takes it, so the next
// item is accepted and searched meanwhile; if the receiver still stalls, that
// second result waits in the sequencer and blocks further items.
// reset clears the masks to zero, empties the output and idles the sequencer.
module cron_next_match_search
	import cnms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	input  logic [2:0]  weekday,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [11:0] next_year,
	output logic [3:0]  next_month,
	output logic [4:0]  next_day_of_month,
	output logic [2:0]  next_weekday,
	output logic [4:0]  next_hour,
	output logic [5:0]  next_minute
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MOD   = 9'b000000010,
		ST_CHECK = 9'b000000100,
		ST_MIN   = 9'b000001000,
		ST_HOUR  = 9'b000010000,
		ST_FIX   = 9'b000100000,
		ST_DAY   = 9'b001000000,
		ST_SKIP  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	cal_pos_t pos_q, pos_d;
	logic [4:0] hour_q, hour_d;
	logic [5:0] minute_q, minute_d;
	logic [STEP_W-1:0] steps_q, steps_d;
	logic [WYEAR_W-1:0] limit_q, limit_d;
	logic [11:0] red_q, red_d;
	logic found_q, found_d;

	// output register, holds one finished item
	logic        out_valid_q;
	logic        res_found_q;
	logic [11:0] res_year_q;
	logic [3:0]  res_month_q;
	logic [4:0]  res_day_q;
	logic [2:0]  res_weekday_q;
	logic [4:0]  res_hour_q;
	logic [5:0]  res_minute_q;
	logic        load_res;

	cfg_t cfg;
	logic [4:0] mlen;
	cal_pos_t pos_nm;

	cnms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// shared calendar unit always looks at the current cursor
	cnms_cal_unit u_cal (
		.pos            (pos_q),
		.month_len      (mlen),
		.pos_next_month (pos_nm)
	);

	// masks padded so that out-of-range positions read as not allowed
	logic [63:0] min_mask64;
	logic [31:0] hour_mask32;
	logic [31:0] dom_mask32;
	logic [15:0] mon_mask16;
	logic [7:0]  wd_mask8;

	assign min_mask64  = {4'd0, cfg.minute_mask};
	assign hour_mask32 = {8'd0, cfg.hour_mask};
	assign dom_mask32  = {1'b0, cfg.day_of_month_mask};
	assign mon_mask16  = {4'd0, cfg.month_mask};
	assign wd_mask8    = {1'b0, cfg.weekday_mask};

	logic [5:0] day_m1;
	logic minute_ok, hour_ok, day_ok, masks_ok, input_ok, day_over;

	assign day_m1    = pos_q.day - 6'd1;
	assign minute_ok = min_mask64[minute_q];
	assign hour_ok   = hour_mask32[hour_q];
	assign day_ok    = (pos_q.day != 6'd0) && dom_mask32[day_m1[4:0]] &&
		wd_mask8[pos_q.weekday] && mon_mask16[pos_q.month];
	assign masks_ok  = (cfg.minute_mask != '0) && (cfg.hour_mask != '0) &&
		(cfg.day_of_month_mask != '0) && (cfg.month_mask != '0) &&
		(cfg.weekday_mask != '0);
	assign input_ok  = masks_ok && (pos_q.month <= 4'(LAST_MONTH)) &&
		(pos_q.weekday <= 3'(LAST_WEEKDAY)) && (hour_q <= 5'(LAST_HOUR)) &&
		(minute_q <= 6'(LAST_MINUTE)) && (pos_q.day != 6'd0) &&
		(pos_q.day <= {1'b0, mlen});
	assign day_over  = pos_q.day > {1'b0, mlen};

	// one day forward, rolling into the next month when past its end
	cal_pos_t pos_step;
	logic [5:0] day_inc;
	logic [2:0] wd_inc;

	always_comb begin
		day_inc = pos_q.day + 6'd1;
		wd_inc = (pos_q.weekday >= 3'(LAST_WEEKDAY)) ? 3'd0 : pos_q.weekday + 3'd1;
		if (day_inc > {1'b0, mlen}) begin
			pos_step = pos_nm;
		end else begin
			pos_step = pos_q;
			pos_step.day = day_inc;
		end
		pos_step.weekday = wd_inc;
	end

	// skipping the rest of a disallowed month
	cal_pos_t pos_skip;
	logic [5:0] rest;

	always_comb begin
		rest = {1'b0, mlen} - pos_q.day;
		pos_skip = pos_nm;
		pos_skip.weekday = mod7_f(6'(pos_q.weekday) + 6'd1 + rest);
	end

	// finished item moves on when the output register is free or being taken
	assign load_res = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		steps_d  = steps_q;
		limit_d  = limit_q;
		red_d    = red_q;
		found_d  = found_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pos_d.year    = {1'b0, year};
					pos_d.ymod    = '0;
					pos_d.month   = month;
					pos_d.day     = {1'b0, day_of_month};
					pos_d.weekday = weekday;
					hour_d        = hour;
					minute_d      = minute;
					red_d         = year;
					limit_d       = {1'b0, year} + WYEAR_W'(MAX_YEARS_AHEAD);
					state_d       = ST_MOD;
				end
			end
			ST_MOD: begin
				// year phase in the 400-year leap cycle
				if (red_q >= 12'(YEAR_CYCLE)) begin
					red_d = red_q - 12'(YEAR_CYCLE);
				end else begin
					pos_d.ymod = red_q[YMOD_W-1:0];
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!input_ok) begin
					found_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					if (!day_ok) begin
						minute_d = '0;
						hour_d = '0;
					end else if (!hour_ok) begin
						minute_d = '0;
					end else begin
						minute_d = minute_q + 6'd1;
					end
					state_d = ST_MIN;
				end
			end
			ST_MIN: begin
				if (minute_ok) begin
					state_d = ST_HOUR;
				end else if (minute_q >= 6'(MINUTES_PER_HR)) begin
					hour_d = hour_q + 5'd1;
					minute_d = '0;
				end else begin
					minute_d = minute_q + 6'd1;
				end
			end
			ST_HOUR: begin
				// minute is kept as found while the hour moves on
				if (hour_ok) begin
					state_d = ST_FIX;
				end else if (hour_q >= 5'(HOURS_PER_DAY)) begin
					pos_d.day = pos_q.day + 6'd1;
					pos_d.weekday = pos_q.weekday + 3'd1;
					hour_d = '0;
				end else begin
					hour_d = hour_q + 5'd1;
				end
			end
			ST_FIX: begin
				if (day_over) begin
					pos_d = pos_nm;
				end
				if (pos_q.weekday >= 3'(DAYS_PER_WEEK)) begin
					pos_d.weekday = 3'd0;
				end
				steps_d = STEP_W'(MAX_DAY_STEPS);
				state_d = ST_DAY;
			end
			ST_DAY: begin
				if (day_ok) begin
					found_d = 1'b1;
					state_d = ST_DONE;
				end else if (steps_q == '0) begin
					found_d = 1'b0;
					state_d = ST_DONE;
				end else begin
					steps_d = steps_q - STEP_W'(1);
					if (pos_q.year >= limit_q) begin
						found_d = 1'b0;
						state_d = ST_DONE;
					end else begin
						pos_d = pos_step;
						state_d = mon_mask16[pos_step.month] ? ST_DAY : ST_SKIP;
					end
				end
			end
			ST_SKIP: begin
				pos_d = pos_skip;
				state_d = mon_mask16[pos_skip.month] ? ST_DAY : ST_SKIP;
			end
			ST_DONE: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			steps_q  <= '0;
			limit_q  <= '0;
			red_q    <= '0;
			found_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			hour_q   <= hour_d;
			minute_q <= minute_d;
			steps_q  <= steps_d;
			limit_q  <= limit_d;
			red_q    <= red_d;
			found_q  <= found_d;
		end
	end

	// output register: a failed search reports all fields as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			res_found_q   <= 1'b0;
			res_year_q    <= '0;
			res_month_q   <= '0;
			res_day_q     <= '0;
			res_weekday_q <= '0;
			res_hour_q    <= '0;
			res_minute_q  <= '0;
		end else if (load_res) begin
			out_valid_q   <= 1'b1;
			res_found_q   <= found_q;
			res_year_q    <= found_q ? pos_q.year[11:0] : 12'd0;
			res_month_q   <= found_q ? pos_q.month : 4'd0;
			res_day_q     <= found_q ? pos_q.day[4:0] : 5'd0;
			res_weekday_q <= found_q ? pos_q.weekday : 3'd0;
			res_hour_q    <= found_q ? hour_q : 5'd0;
			res_minute_q  <= found_q ? minute_q : 6'd0;
		end else if (out_ready) begin
			out_valid_q   <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign found             = res_found_q;
	assign next_year         = res_year_q;
	assign next_month        = res_month_q;
	assign next_day_of_month = res_day_q;
	assign next_weekday      = res_weekday_q;
	assign next_hour         = res_hour_q;
	assign next_minute       = res_minute_q;

endmodule
